/* hw/rtl/xcfp_pkg.sv */
// ----------------------------------------------------------------------------
// XOR checksum frame parser package
// Shared widths, frame layout, register indexes and status codes of the frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package xcfp_pkg;

  // Field widths.
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CFG_IDX_W = 1;

  // Frame layout: header at position 0, length at 1, payload from 2.
  localparam logic [BYTE_W-1:0] POS_HEADER    = 8'd0;
  localparam logic [BYTE_W-1:0] POS_LENGTH    = 8'd1;
  localparam logic [BYTE_W-1:0] PAYLOAD_START = 8'd2;
  localparam logic [BYTE_W-1:0] MAX_PAYLOAD   = 8'd253;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEADER_BYTE    = 1'b0,
    CFG_PAYLOAD_LENGTH = 1'b1
  } cfg_idx_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_PROGRESS         = 3'd0,
    ST_NO_HEADER        = 3'd1,
    ST_INVALID_SIZE     = 3'd2,
    ST_INVALID_CHECKSUM = 3'd3,
    ST_SUCCESS          = 3'd4
  } status_t;

endpackage

`default_nettype wire

/* hw/rtl/xor_checksum_frame_parser.sv */
// ----------------------------------------------------------------------------
// XOR checksum frame parser
// Parses a byte stream into header, length, payload and checksum words and
// gives one result word for every received word.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake          Word
//  in_       input      in_valid/in_ready  in_rx_byte
//  out_      output     out_valid/out_ready status, payload write, index, byte
//  cfg_      input      cfg_valid/cfg_ready register index and write data
//
// One word is taken per cycle while the result port is not stalled; its result
// is presented on the result port through an input and a result register.
// The frame position and running XOR are updated as a word moves from the
// input register into the result register, so consecutive words chain at
// full rate. A stalled result holds while one more word waits in the input
// register. Synchronous reset clears frame state, configuration and valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module xor_checksum_frame_parser (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  wire logic [xcfp_pkg::BYTE_W-1:0]    in_rx_byte,
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output      logic [xcfp_pkg::STATUS_W-1:0]  out_status,
  output      logic                           out_payload_write,
  output      logic [xcfp_pkg::BYTE_W-1:0]    out_payload_index,
  output      logic [xcfp_pkg::BYTE_W-1:0]    out_payload_byte,
  input  wire logic                           cfg_valid,
  output      logic                           cfg_ready,
  input  wire logic [xcfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [xcfp_pkg::BYTE_W-1:0]    cfg_data
);

  import xcfp_pkg::*;

  logic [BYTE_W-1:0]   header_r;
  logic [BYTE_W-1:0]   length_r;
  logic [BYTE_W-1:0]   pos_r, pos_nxt;
  logic [BYTE_W-1:0]   xor_r, xor_nxt;
  logic                in_vld_r;
  logic [BYTE_W-1:0]   in_byte_r;
  logic                out_vld_r;
  status_t             status_r, status_nxt;
  logic                wr_r, wr_nxt;
  logic [BYTE_W-1:0]   idx_r, idx_nxt;
  logic [BYTE_W-1:0]   val_r, val_nxt;
  logic                advance;
  logic [BYTE_W-1:0]   count;
  logic [BYTE_W:0]     pay_end;

  // The configuration port is always able to take a write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= '0;
      length_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_HEADER_BYTE:    header_r <= cfg_data;
        CFG_PAYLOAD_LENGTH: length_r <= cfg_data;
        default:            header_r <= header_r;
      endcase
    end
  end

  // The input register moves on when the result register is free or drains.
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
  end

  // Payload count saturates so that the position fits in one byte.
  assign count   = (length_r > MAX_PAYLOAD) ? MAX_PAYLOAD : length_r;
  assign pay_end = {1'b0, count} + {1'b0, PAYLOAD_START};

  // Frame decode for the word in the input register.
  always_comb begin
    pos_nxt    = pos_r;
    xor_nxt    = xor_r;
    status_nxt = ST_PROGRESS;
    wr_nxt     = 1'b0;
    idx_nxt    = '0;
    val_nxt    = '0;
    priority if (pos_r == POS_HEADER) begin
      if (in_byte_r != header_r) begin
        status_nxt = ST_NO_HEADER;
      end else begin
        pos_nxt = POS_LENGTH;
      end
    end else if (pos_r == POS_LENGTH) begin
      if (in_byte_r != length_r) begin
        status_nxt = ST_INVALID_SIZE;
        pos_nxt    = POS_HEADER;
      end else begin
        xor_nxt = in_byte_r;
        pos_nxt = PAYLOAD_START;
      end
    end else if ({1'b0, pos_r} >= pay_end) begin
      pos_nxt    = POS_HEADER;
      status_nxt = (xor_r == in_byte_r) ? ST_SUCCESS : ST_INVALID_CHECKSUM;
    end else begin
      wr_nxt  = 1'b1;
      idx_nxt = pos_r - PAYLOAD_START;
      val_nxt = in_byte_r;
      xor_nxt = xor_r ^ in_byte_r;
      pos_nxt = pos_r + 8'd1;
    end
  end

  // Frame state follows each word as it is decoded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_HEADER;
      xor_r <= '0;
    end else if (advance) begin
      pos_r <= pos_nxt;
      xor_r <= xor_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status_r <= status_nxt;
      wr_r     <= wr_nxt;
      idx_r    <= idx_nxt;
      val_r    <= val_nxt;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_status        = status_r;
  assign out_payload_write = wr_r;
  assign out_payload_index = idx_r;
  assign out_payload_byte  = val_r;

endmodule

`default_nettype wire

/* hw/rtl/xcfp_checker.sv */
// ----------------------------------------------------------------------------
// XOR checksum frame parser checker
// Port-level checks on the result words of the frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

module xcfp_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [xcfp_pkg::STATUS_W-1:0] out_status,
  input wire logic                          out_payload_write,
  input wire logic [xcfp_pkg::BYTE_W-1:0]   out_payload_index,
  input wire logic [xcfp_pkg::BYTE_W-1:0]   out_payload_byte
);

  import xcfp_pkg::*;

  // A payload word is always reported as in progress.
  a_write_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_payload_write) |-> (out_status == ST_PROGRESS))
    else $error("payload word carries a final status");

  // Words that are not payload carry zero index and byte.
  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_payload_write) |->
      (out_payload_index == '0 && out_payload_byte == '0))
    else $error("non-payload word carries payload fields");

  // Only the defined status codes appear on a result word.
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= ST_SUCCESS))
    else $error("result word carries an undefined status");

  // The input side is ready whenever the result side can move.
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input blocked while the result side is free");

  // A stalled result word holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_status) &&
      $stable(out_payload_write) && $stable(out_payload_index) &&
      $stable(out_payload_byte)))
    else $error("stalled result word changed");

endmodule

bind xor_checksum_frame_parser xcfp_checker u_xcfp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_status        (out_status),
  .out_payload_write (out_payload_write),
  .out_payload_index (out_payload_index),
  .out_payload_byte  (out_payload_byte)
);

`default_nettype wire
